// ===== hdl/pta_pkg.sv =====
package pta_pkg;

  localparam int MAX_VERTS = 64;
  localparam int TAG_BITS  = 16;

  // Handle width on the ports is fixed; the store keeps only the bits that survive.
  localparam int PORT_TAG_W = 16;
  localparam int STORE_W    = (TAG_BITS < PORT_TAG_W) ? TAG_BITS : PORT_TAG_W;
  localparam int IDX_W      = $clog2(MAX_VERTS);
  localparam int CNT_W      = $clog2(MAX_VERTS + 1);
  localparam int K_W        = CNT_W + 1;

  localparam logic [1:0] CMD_BEGIN  = 2'd0;
  localparam logic [1:0] CMD_VERTEX = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;

  localparam logic [3:0] MODE_TRIS    = 4'd4;
  localparam logic [3:0] MODE_STRIP   = 4'd5;
  localparam logic [3:0] MODE_FAN     = 4'd6;
  localparam logic [3:0] MODE_QUADS   = 4'd7;
  localparam logic [3:0] MODE_QSTRIP  = 4'd8;
  localparam logic [3:0] MODE_POLYGON = 4'd9;

  typedef struct packed {
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
    logic [IDX_W-1:0] addr_c;
    logic [K_W-1:0]   next_k;
    logic             next_sub;
    logic             more;
  } tri_plan_t;

  function automatic logic [K_W-1:0] start_k(input logic [3:0] mode);
    logic [K_W-1:0] k;
    k = '0;
    if (mode == MODE_FAN || mode == MODE_POLYGON) begin
      k = K_W'(1);
    end
    return k;
  endfunction

  // True when the triangle with base index k still fits in n vertices.
  function automatic logic tri_fits(input logic [3:0] mode, input logic [K_W-1:0] k,
                                    input logic [CNT_W-1:0] n);
    logic [K_W-1:0] nn;
    logic           fits;
    nn   = K_W'(n);
    fits = 1'b0;
    unique case (mode)
      MODE_TRIS, MODE_STRIP:    fits = (k + K_W'(2)) < nn;
      MODE_FAN, MODE_POLYGON:   fits = (k + K_W'(1)) < nn;
      MODE_QUADS, MODE_QSTRIP:  fits = (k + K_W'(3)) < nn;
      default:                  fits = 1'b0;
    endcase
    return fits;
  endfunction

endpackage

// ===== hdl/pta_corner_gen.sv =====
module pta_corner_gen
  import pta_pkg::*;
(
  input  logic [3:0]       mode,
  input  logic [CNT_W-1:0] n,
  input  logic [K_W-1:0]   k,
  input  logic             sub,
  output tri_plan_t        plan
);

  logic [K_W-1:0] k1, k2, k3;
  logic [K_W-1:0] ia, ib, ic;

  assign k1 = k + K_W'(1);
  assign k2 = k + K_W'(2);
  assign k3 = k + K_W'(3);

  always_comb begin
    ia            = k;
    ib            = k1;
    ic            = k2;
    plan.next_k   = k1;
    plan.next_sub = 1'b0;
    unique case (mode)
      MODE_TRIS: begin
        plan.next_k = k3;
      end
      MODE_FAN, MODE_POLYGON: begin
        ia = '0;
        ib = k;
        ic = k1;
      end
      MODE_QUADS: begin
        if (sub) begin
          ib          = k2;
          ic          = k3;
          plan.next_k = k + K_W'(4);
        end else begin
          plan.next_k   = k;
          plan.next_sub = 1'b1;
        end
      end
      MODE_QSTRIP: begin
        if (sub) begin
          ib          = k3;
          ic          = k2;
          plan.next_k = k2;
        end else begin
          ic            = k3;
          plan.next_k   = k;
          plan.next_sub = 1'b1;
        end
      end
      default: begin
      end
    endcase
    plan.addr_a = ia[IDX_W-1:0];
    plan.addr_b = ib[IDX_W-1:0];
    plan.addr_c = ic[IDX_W-1:0];
    plan.more   = tri_fits(mode, plan.next_k, n);
  end

endmodule

// ===== hdl/primitive_to_triangle_assembler.sv =====
// Primitive assembler: turns begin / vertex / end command words into a triangle list.
// Commands enter on start while busy is low; in_cmd selects begin (latches in_prim_mode),
// vertex (stores in_vertex_tag) or end. Begin and vertex words leave busy low, so a
// vertex stream can run at one word per cycle.
// An end word with an open primitive that holds enough vertices raises busy while the
// triangles are produced. Each triangle needs three reads of the vertex memory, which has
// one read port, so each triangle passes through states RD_A, RD_B, RD_C and EMIT,
// and no new word is taken until the last triangle's EMIT is done. Each triangle is
// shown on the out_ ports for one cycle with out_strobe high; out_last_triangle marks
// the final one and out_vertices_dropped reports that vertices beyond the buffer depth
// were discarded. An end word that yields no triangle leaves busy low.
// The receiver cannot stall: every strobe is taken.
// Reset closes any primitive and empties the buffer; the vertex memory is not cleared,
// since only entries written after the last begin or end are ever read.
module primitive_to_triangle_assembler
  import pta_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_cmd,
  input  logic [3:0]            in_prim_mode,
  input  logic [15:0]           in_vertex_tag,
  output logic                  out_strobe,
  output logic [PORT_TAG_W-1:0] out_corner_a,
  output logic [PORT_TAG_W-1:0] out_corner_b,
  output logic [PORT_TAG_W-1:0] out_corner_c,
  output logic                  out_last_triangle,
  output logic                  out_vertices_dropped
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD_A = 3'd1;
  localparam logic [2:0] S_RD_B = 3'd2;
  localparam logic [2:0] S_RD_C = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [STORE_W-1:0] vstore [MAX_VERTS];
  logic [STORE_W-1:0] rd_data_r;
  logic [IDX_W-1:0]   rd_addr;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [3:0]       mode_r, mode_nxt;
  logic             open_r, open_nxt;
  logic             ovf_r, ovf_nxt;

  logic [3:0]       job_mode_r, job_mode_nxt;
  logic [CNT_W-1:0] job_n_r, job_n_nxt;
  logic             job_ovf_r, job_ovf_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic             sub_r, sub_nxt;

  logic [STORE_W-1:0] cap_a_r, cap_b_r;
  logic               strobe_r, strobe_nxt;
  logic [STORE_W-1:0] oa_r, ob_r, oc_r;
  logic               olast_r, odrop_r;

  logic      accept;
  logic      wr_en;
  tri_plan_t plan;

  assign accept = start && (state_r == S_IDLE);
  assign wr_en  = accept && (in_cmd == CMD_VERTEX) && (count_r < CNT_W'(MAX_VERTS));

  pta_corner_gen u_corner_gen (
    .mode (job_mode_r),
    .n    (job_n_r),
    .k    (k_r),
    .sub  (sub_r),
    .plan (plan)
  );

  always_comb begin
    rd_addr = plan.addr_a;
    unique case (state_r)
      S_RD_B:  rd_addr = plan.addr_b;
      S_RD_C:  rd_addr = plan.addr_c;
      default: rd_addr = plan.addr_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vstore[count_r[IDX_W-1:0]] <= in_vertex_tag[STORE_W-1:0];
    end
    rd_data_r <= vstore[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    mode_nxt     = mode_r;
    open_nxt     = open_r;
    ovf_nxt      = ovf_r;
    job_mode_nxt = job_mode_r;
    job_n_nxt    = job_n_r;
    job_ovf_nxt  = job_ovf_r;
    k_nxt        = k_r;
    sub_nxt      = sub_r;
    strobe_nxt   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_BEGIN: begin
              mode_nxt  = in_prim_mode;
              open_nxt  = 1'b1;
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            CMD_VERTEX: begin
              if (count_r < CNT_W'(MAX_VERTS)) begin
                count_nxt = count_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_END: begin
              job_mode_nxt = mode_r;
              job_n_nxt    = count_r;
              job_ovf_nxt  = ovf_r;
              k_nxt        = start_k(mode_r);
              sub_nxt      = 1'b0;
              if (open_r && tri_fits(mode_r, start_k(mode_r), count_r)) begin
                state_nxt = S_RD_A;
              end
              open_nxt  = 1'b0;
              mode_nxt  = '0;
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: state_nxt = S_RD_C;
      S_RD_C: state_nxt = S_EMIT;
      S_EMIT: begin
        strobe_nxt = 1'b1;
        k_nxt      = plan.next_k;
        sub_nxt    = plan.next_sub;
        state_nxt  = plan.more ? S_RD_A : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      mode_r   <= '0;
      open_r   <= 1'b0;
      ovf_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      mode_r   <= mode_nxt;
      open_r   <= open_nxt;
      ovf_r    <= ovf_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Read data is registered, so each corner arrives in the cycle after its address and is caught a state later.
  always_ff @(posedge clk) begin
    job_mode_r <= job_mode_nxt;
    job_n_r    <= job_n_nxt;
    job_ovf_r  <= job_ovf_nxt;
    k_r        <= k_nxt;
    sub_r      <= sub_nxt;
    if (state_r == S_RD_B) begin
      cap_a_r <= rd_data_r;
    end
    if (state_r == S_RD_C) begin
      cap_b_r <= rd_data_r;
    end
    if (state_r == S_EMIT) begin
      oa_r    <= cap_a_r;
      ob_r    <= cap_b_r;
      oc_r    <= rd_data_r;
      olast_r <= !plan.more;
      odrop_r <= job_ovf_r;
    end
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_strobe           = strobe_r;
  assign out_corner_a         = PORT_TAG_W'(oa_r);
  assign out_corner_b         = PORT_TAG_W'(ob_r);
  assign out_corner_c         = PORT_TAG_W'(oc_r);
  assign out_last_triangle    = olast_r;
  assign out_vertices_dropped = odrop_r;

endmodule

// ===== hdl/pta_checker.sv =====
module pta_checker
  import pta_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_cmd,
  input logic       out_strobe,
  input logic       out_last_triangle
);

  // No triangle leaves in the cycle after a command word is taken.
  a_no_strobe_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_strobe)
    else $error("triangle word right after an accepted command");

  // Triangles are spaced by the memory reads; two in a row means a lost read.
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("triangle words on consecutive cycles");

  a_more_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_triangle) |-> busy)
    else $error("idle although the primitive has more triangles");

  a_short_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == CMD_BEGIN || in_cmd == CMD_VERTEX)) |=> !busy)
    else $error("begin or vertex word left the block busy");

  a_busy_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_cmd == CMD_END))
    else $error("busy rose without an end word");

endmodule

bind primitive_to_triangle_assembler pta_checker u_pta_checker (.*);

// ===== dv/testbench.sv =====
module testbench;
  import pta_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [3:0] MODE_POINTS  = 4'd0;
  localparam logic [3:0] MODE_LINES   = 4'd1;
  localparam logic [3:0] MODE_UNKNOWN = 4'd15;
  localparam logic [15:0] KEEP_MASK   = 16'((64'd1 << STORE_W) - 64'd1);
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic        last;
    logic        dropped;
  } tri_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = CMD_BEGIN;
  logic [3:0]  in_prim_mode = MODE_POINTS;
  logic [15:0] in_vertex_tag = '0;
  logic        out_strobe;
  logic [15:0] out_corner_a;
  logic [15:0] out_corner_b;
  logic [15:0] out_corner_c;
  logic        out_last_triangle;
  logic        out_vertices_dropped;

  // Shadow of the assembler state, updated on every accepted word.
  logic [15:0] buf_tags [MAX_VERTS];
  int          buf_count = 0;
  logic [3:0]  buf_mode = MODE_POINTS;
  bit          buf_open = 1'b0;
  bit          buf_overflow = 1'b0;

  tri_t pending_tris[$];
  int   failures = 0;
  int   sender_idle = 0;
  int   cycle_count = 0;

  primitive_to_triangle_assembler uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_prim_mode        (in_prim_mode),
    .in_vertex_tag       (in_vertex_tag),
    .out_strobe          (out_strobe),
    .out_corner_a        (out_corner_a),
    .out_corner_b        (out_corner_b),
    .out_corner_c        (out_corner_c),
    .out_last_triangle   (out_last_triangle),
    .out_vertices_dropped(out_vertices_dropped)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic push_tri(input int i, input int j, input int k);
    tri_t t;
    t.a       = buf_tags[i];
    t.b       = buf_tags[j];
    t.c       = buf_tags[k];
    t.last    = 1'b0;
    t.dropped = buf_overflow;
    pending_tris.push_back(t);
  endtask

  task automatic predict_word(input logic [1:0] cmd, input logic [3:0] mode,
                              input logic [15:0] tag);
    int   first;
    int   k;
    tri_t t;
    case (cmd)
      CMD_BEGIN: begin
        buf_mode     = mode;
        buf_open     = 1'b1;
        buf_count    = 0;
        buf_overflow = 1'b0;
      end
      CMD_VERTEX: begin
        if (buf_count < MAX_VERTS) begin
          buf_tags[buf_count] = tag & KEEP_MASK;
          buf_count++;
        end else begin
          buf_overflow = 1'b1;
        end
      end
      CMD_END: begin
        first = pending_tris.size();
        if (buf_open && buf_count != 0) begin
          case (buf_mode)
            MODE_TRIS: begin
              for (k = 0; k + 2 < buf_count; k += 3) push_tri(k, k + 1, k + 2);
            end
            MODE_STRIP: begin
              for (k = 0; k + 2 < buf_count; k++) push_tri(k, k + 1, k + 2);
            end
            MODE_FAN, MODE_POLYGON: begin
              for (k = 1; k + 1 < buf_count; k++) push_tri(0, k, k + 1);
            end
            MODE_QUADS: begin
              for (k = 0; k + 3 < buf_count; k += 4) begin
                push_tri(k, k + 1, k + 2);
                push_tri(k, k + 2, k + 3);
              end
            end
            MODE_QSTRIP: begin
              for (k = 0; k + 3 < buf_count; k += 2) begin
                push_tri(k, k + 1, k + 3);
                push_tri(k, k + 3, k + 2);
              end
            end
            default: begin
            end
          endcase
        end
        if (pending_tris.size() > first) begin
          t = pending_tris.pop_back();
          t.last = 1'b1;
          pending_tris.push_back(t);
        end
        buf_open     = 1'b0;
        buf_mode     = MODE_POINTS;
        buf_count    = 0;
        buf_overflow = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  // Start stays high after a word is taken so that back-to-back words need no
  // extra edge; it is lowered only when the sender idles or drains.
  task automatic send_word(input logic [1:0] cmd, input logic [3:0] mode,
                           input logic [15:0] tag);
    if ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_prim_mode  <= mode;
    in_vertex_tag <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_word(cmd, mode, tag);
  endtask

  task automatic wait_for_triangles();
    start <= 1'b0;
    while (pending_tris.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tri_t want;
    if (rst_n && out_strobe) begin
      if (pending_tris.size() == 0) begin
        failures++;
        $display("%0t: unexpected triangle, expected none, actual %h %h %h", $time,
                 out_corner_a, out_corner_b, out_corner_c);
      end else begin
        want = pending_tris.pop_front();
        check_field("corner_a", want.a, out_corner_a);
        check_field("corner_b", want.b, out_corner_b);
        check_field("corner_c", want.c, out_corner_c);
        check_field("last_triangle", 16'(want.last), 16'(out_last_triangle));
        check_field("vertices_dropped", 16'(want.dropped), 16'(out_vertices_dropped));
      end
    end
  end

  // Vertices with nothing open are still buffered, then thrown away by the end.
  task automatic test_stray_words();
    send_word(CMD_VERTEX, MODE_UNKNOWN, 16'hFFFF);
    send_word(CMD_END, MODE_POINTS, 16'h0000);
    send_word(CMD_UNUSED, MODE_UNKNOWN, 16'hFFFF);
    send_word(CMD_END, MODE_UNKNOWN, 16'h0000);
  endtask

  task automatic test_restart_strip();
    send_word(CMD_BEGIN, MODE_TRIS, 16'h0000);
    send_word(CMD_VERTEX, MODE_POINTS, 16'h1111);
    send_word(CMD_BEGIN, MODE_STRIP, 16'hFFFF);
    send_word(CMD_VERTEX, MODE_POINTS, 16'h0000);
    send_word(CMD_VERTEX, MODE_UNKNOWN, 16'hFFFF);
    send_word(CMD_VERTEX, MODE_POINTS, 16'h8001);
    send_word(CMD_UNUSED, MODE_STRIP, 16'h5A5A);
    send_word(CMD_VERTEX, MODE_POINTS, 16'h7FFE);
    send_word(CMD_END, MODE_POINTS, 16'h0000);
  endtask

  task automatic test_short_primitives();
    send_word(CMD_BEGIN, MODE_QUADS, 16'h0000);
    repeat (3) send_word(CMD_VERTEX, MODE_POINTS, 16'($urandom()));
    send_word(CMD_END, MODE_POINTS, 16'h0000);
    send_word(CMD_BEGIN, MODE_LINES, 16'h0000);
    repeat (4) send_word(CMD_VERTEX, MODE_POINTS, 16'($urandom()));
    send_word(CMD_END, MODE_POINTS, 16'h0000);
  endtask

  // A full fan gives the longest triangle burst; the extra vertices are dropped.
  task automatic test_buffer_overflow();
    send_word(CMD_BEGIN, MODE_FAN, 16'h0000);
    repeat (MAX_VERTS + 2) send_word(CMD_VERTEX, MODE_POINTS, 16'($urandom()));
    send_word(CMD_END, MODE_POINTS, 16'h0000);
    wait_for_triangles();
  endtask

  task automatic test_random_primitives(input int idle_pct, input int budget);
    int         sent;
    int         nv;
    int         i;
    logic [3:0] mode;
    sent = 0;
    sender_idle = idle_pct;
    while (sent < budget) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(99) < 88) begin
          mode = 4'($urandom_range(MODE_TRIS, MODE_POLYGON));
        end else begin
          mode = 4'($urandom_range(15));
        end
        if ($urandom_range(99) < 4) begin
          nv = $urandom_range(MAX_VERTS - 4, MAX_VERTS + 6);
        end else begin
          nv = $urandom_range(0, 12);
        end
        send_word(CMD_BEGIN, mode, 16'($urandom()));
        for (i = 0; i < nv; i++) begin
          if ($urandom_range(29) == 0) begin
            send_word(CMD_BEGIN, 4'($urandom_range(MODE_TRIS, MODE_POLYGON)),
                      16'($urandom()));
            sent++;
          end
          send_word(CMD_VERTEX, 4'($urandom()), 16'($urandom()));
        end
        send_word(CMD_END, 4'($urandom()), 16'($urandom()));
        sent += nv + 2;
      end else begin
        send_word(2'($urandom_range(3)), 4'($urandom()), 16'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle = 24;
    test_stray_words();
    test_restart_strip();
    test_short_primitives();
    test_buffer_overflow();
    test_random_primitives(24, 110);
    wait_for_triangles();
    test_random_primitives(60, 110);
    wait_for_triangles();
    test_random_primitives(0, 110);
    start <= 1'b0;
    while (pending_tris.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
